@@ design/csf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types and constants of the cascaded 3x3 sharpening filter.
// ----------------------------------------------------------------------------
package csf_pkg;

    // fixed frame height limits and counter widths
    localparam int HGT_W      = 12;
    localparam int ROW_W      = 11;
    localparam int HEIGHT_MAX = 2048;
    localparam int PIX_W      = 24;

    // configuration register indexes
    localparam logic [1:0] REG_PASS_COUNT   = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // input item
    typedef struct packed {
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
        logic       flush;
        logic       frame_start;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] out_c;
        logic       frame_end;
    } t_out_item;

    // step token moving down the cascade
    typedef struct packed {
        logic             tok;
        logic             valid;
        logic             first;
        logic             last;
        logic [PIX_W-1:0] pix;
    } t_tok;

endpackage

@@ design/csf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/csf_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_stage
// One sharpening pass: position counters, two-line store, window and kernel.
// ----------------------------------------------------------------------------
module csf_stage import csf_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int FW = WW + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_active,
    input  logic [WW-1:0]    i_width,
    input  logic [HGT_W-1:0] i_height,
    input  t_tok             i_item,
    output t_tok             o_item
);

    // per-channel kernel with clamp to 0..255
    function automatic logic [7:0] sharp_ch(input logic [7:0] c, input logic [7:0] l,
                                            input logic [7:0] r, input logic [7:0] u,
                                            input logic [7:0] d);
        logic signed [11:0] v;
        v = $signed(({4'd0, c} * 12'd5) - {4'd0, l} - {4'd0, r} - {4'd0, u} - {4'd0, d});
        if (v < 12'sd0) begin
            return 8'd0;
        end else if (v > 12'sd255) begin
            return 8'd255;
        end else begin
            return v[7:0];
        end
    endfunction

    // position state
    logic             r_live, n_live;
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [FW-1:0]    r_fill, n_fill;

    // entry-side decode
    logic             start, live_c, proc, fill_le, oc_last, row_last;
    logic             first_o, last_o, border;
    logic [CW-1:0]    col_c, col_e, oc, col_next;
    logic [WW-1:0]    col_inc;
    logic [ROW_W-1:0] row_c, orow;
    logic [FW-1:0]    fill_c;

    // first half registers
    logic             r_a_act, r_a_tok, r_a_proc, r_a_emit, r_a_first, r_a_last;
    logic             r_a_border;
    logic [CW-1:0]    r_a_col;
    logic [PIX_W-1:0] r_a_x;
    t_tok             r_a_pt;
    logic             r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;

    // line store and window
    logic [2*PIX_W-1:0] ram_q, rd_word, wdata;
    logic               we, fwd;
    logic [PIX_W-1:0]   line_a, line_b;
    logic [PIX_W-1:0]   r_ctr, r_left, r_up, r_dn;
    logic [PIX_W-1:0]   sharp;
    t_tok               r_out, n_out;

    // counter decode for the item entering the stage
    always_comb begin
        start    = i_item.tok && i_item.valid && i_item.first;
        live_c   = start || r_live;
        col_c    = start ? '0 : r_col;
        row_c    = start ? '0 : r_row;
        fill_c   = start ? '0 : r_fill;
        proc     = i_item.tok && live_c;
        col_e    = (WW'(col_c) >= i_width) ? '0 : col_c;
        col_inc  = WW'(col_e) + WW'(1);
        col_next = (col_inc >= i_width) ? '0 : CW'(col_inc);
        fill_le  = fill_c <= FW'(i_width);
        oc       = (col_e == '0) ? CW'(i_width - WW'(1)) : col_e - CW'(1);
        orow     = (HGT_W'(row_c) >= i_height) ? ROW_W'(i_height - HGT_W'(1)) : row_c;
        oc_last  = WW'(oc) == (i_width - WW'(1));
        row_last = HGT_W'(orow) == (i_height - HGT_W'(1));
        first_o  = (orow == '0) && (oc == '0);
        last_o   = row_last && oc_last;
        border   = (orow == '0) || row_last || (oc == '0) || oc_last;

        n_live = r_live;
        n_col  = r_col;
        n_row  = r_row;
        n_fill = r_fill;
        if (i_en && i_active && proc) begin
            n_live = live_c;
            n_col  = col_next;
            n_row  = row_c;
            n_fill = fill_c;
            if (fill_le) begin
                n_fill = fill_c + FW'(1);
            end else if (oc_last) begin
                if (last_o) begin
                    n_live = 1'b0;
                end else begin
                    n_row = orow + ROW_W'(1);
                end
            end
        end
    end

    // line store access with same-address forwarding
    assign rd_word = r_fwd ? r_fwd_data : ram_q;
    assign line_a  = rd_word[PIX_W-1:0];
    assign line_b  = rd_word[2*PIX_W-1:PIX_W];
    assign wdata   = {r_a_x, line_b};
    assign we      = i_en && r_a_act && r_a_proc;
    assign fwd     = we && (r_a_col == col_e);

    csf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_a_col),
        .i_wdata (wdata),
        .i_re    (i_en),
        .i_raddr (col_e),
        .o_rdata (ram_q)
    );

    // kernel: centre and left from the middle row history, right is the
    // middle row of the new column, up and down from the previous column
    assign sharp = {sharp_ch(r_ctr[23:16], r_left[23:16], line_b[23:16], r_up[23:16],
                             r_dn[23:16]),
                    sharp_ch(r_ctr[15:8],  r_left[15:8],  line_b[15:8],  r_up[15:8],
                             r_dn[15:8]),
                    sharp_ch(r_ctr[7:0],   r_left[7:0],   line_b[7:0],   r_up[7:0],
                             r_dn[7:0])};

    // result of the second half
    always_comb begin
        if (!r_a_act) begin
            n_out = r_a_pt;
        end else begin
            n_out.tok   = r_a_tok;
            n_out.valid = r_a_proc && r_a_emit;
            n_out.first = r_a_first;
            n_out.last  = r_a_last;
            n_out.pix   = r_a_border ? '0 : sharp;
        end
    end

    // state, pipeline and window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
            r_a_tok <= 1'b0;
            r_a_act <= 1'b0;
            r_a_proc <= 1'b0;
            r_a_pt  <= '0;
            r_fwd   <= 1'b0;
            r_out   <= '0;
            r_ctr   <= '0;
            r_left  <= '0;
            r_up    <= '0;
            r_dn    <= '0;
        end else begin
            r_live <= n_live;
            r_col  <= n_col;
            r_row  <= n_row;
            r_fill <= n_fill;
            if (i_en) begin
                r_a_act    <= i_active;
                r_a_tok    <= i_item.tok;
                r_a_proc   <= proc;
                r_a_emit   <= !fill_le;
                r_a_first  <= first_o;
                r_a_last   <= last_o;
                r_a_border <= border;
                r_a_col    <= col_e;
                r_a_x      <= i_item.valid ? i_item.pix : '0;
                r_a_pt     <= i_item;
                r_fwd      <= fwd;
                r_fwd_data <= wdata;
                r_out      <= n_out;
                if (r_a_act && r_a_proc) begin
                    r_left <= r_ctr;
                    r_ctr  <= line_b;
                    r_up   <= line_a;
                    r_dn   <= r_a_x;
                end
            end
        end
    end

    assign o_item = r_out;

endmodule

@@ design/cascaded_sharpen_filter_3x3_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_sharpen_filter_3x3_top
// Cascade of 3x3 sharpening passes over a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// Takes one pixel or flush transfer per clock and keeps that rate as long as
// results are taken. Every transfer walks through MAX_PASSES stages, each a
// first half registered at the accepting edge and a second half, and the last
// stage feeds the output register; stages beyond pass_count only forward.
// Each stage is split in two halves by the registered read of its line store.
// Each active pass adds frame_width+1 transfers of delay, pushed out with
// flush transfers. Line stores need no clearing after reset. Write registers
// only while idle.
// ----------------------------------------------------------------------------
module cascaded_sharpen_filter_3x3_top import csf_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_PASSES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    // result stream
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > 12) ? WW : 12;
    localparam int PW = $clog2(MAX_PASSES + 1) + 1;

    logic [3:0]       r_pass_count;
    logic [11:0]      r_frame_width;
    logic [11:0]      r_frame_height;
    logic [WW-1:0]    eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [PW-1:0]    pass_n;
    logic [XW-1:0]    fw_x;
    logic             en, in_xfer, in_pix;
    logic             r_byp_live;
    logic [WW-1:0]    r_byp_col;
    logic [HGT_W-1:0] r_byp_row;
    logic             byp_last;
    logic [WW-1:0]    byp_col_c;
    logic [HGT_W-1:0] byp_row_c;
    t_tok             chain [MAX_PASSES+1];
    logic             r_out_valid;
    t_out_item        r_out_data;

    // register file
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count   <= 4'd0;
            r_frame_width  <= 12'd640;
            r_frame_height <= 12'd480;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_PASS_COUNT:   r_pass_count   <= pwdata[3:0];
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[11:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PASS_COUNT:   prdata = {28'd0, r_pass_count};
            REG_FRAME_WIDTH:  prdata = {20'd0, r_frame_width};
            REG_FRAME_HEIGHT: prdata = {20'd0, r_frame_height};
            default:          prdata = 32'd0;
        endcase
    end

    // clamped settings
    always_comb begin
        fw_x = XW'(r_frame_width);
        if (fw_x < XW'(3)) begin
            eff_w = WW'(3);
        end else if (fw_x > XW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_x);
        end
        if (r_frame_height < 12'd3) begin
            eff_h = HGT_W'(3);
        end else if (r_frame_height > HGT_W'(HEIGHT_MAX)) begin
            eff_h = HGT_W'(HEIGHT_MAX);
        end else begin
            eff_h = r_frame_height;
        end
        pass_n = (PW'(r_pass_count) > PW'(MAX_PASSES)) ? PW'(MAX_PASSES) : PW'(r_pass_count);
    end

    // whole cascade advances when the output register can take a result
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign in_xfer = i_valid && en;
    assign in_pix  = !i_data.flush;

    // frame position for the pass-through case
    always_comb begin
        byp_col_c = (i_data.frame_start || r_byp_col >= eff_w) ?
                    (i_data.frame_start ? '0 : eff_w - WW'(1)) : r_byp_col;
        byp_row_c = (i_data.frame_start || r_byp_row >= eff_h) ?
                    (i_data.frame_start ? '0 : eff_h - HGT_W'(1)) : r_byp_row;
        byp_last  = (r_byp_live || i_data.frame_start) &&
                    (byp_row_c == eff_h - HGT_W'(1)) && (byp_col_c == eff_w - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_live <= 1'b0;
            r_byp_col  <= '0;
            r_byp_row  <= '0;
        end else if (in_xfer && in_pix && (r_byp_live || i_data.frame_start)) begin
            if (byp_last) begin
                r_byp_live <= 1'b0;
                r_byp_col  <= byp_col_c;
                r_byp_row  <= byp_row_c;
            end else if (byp_col_c + WW'(1) >= eff_w) begin
                r_byp_live <= 1'b1;
                r_byp_col  <= '0;
                r_byp_row  <= byp_row_c + HGT_W'(1);
            end else begin
                r_byp_live <= 1'b1;
                r_byp_col  <= byp_col_c + WW'(1);
                r_byp_row  <= byp_row_c;
            end
        end
    end

    // token entering the cascade
    always_comb begin
        chain[0].tok   = in_xfer;
        chain[0].valid = in_pix;
        chain[0].first = in_pix && i_data.frame_start;
        chain[0].last  = byp_last;
        chain[0].pix   = {i_data.chan_c, i_data.chan_b, i_data.chan_a};
    end

    // one stage per pass
    for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
        csf_stage #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_active (PW'(s) < pass_n),
            .i_width  (eff_w),
            .i_height (eff_h),
            .i_item   (chain[s]),
            .o_item   (chain[s+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain[MAX_PASSES].tok && chain[MAX_PASSES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data.out_a     <= chain[MAX_PASSES].pix[7:0];
            r_out_data.out_b     <= chain[MAX_PASSES].pix[15:8];
            r_out_data.out_c     <= chain[MAX_PASSES].pix[23:16];
            r_out_data.frame_end <= chain[MAX_PASSES].last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef ASSERT_OFF
    // a waiting result freezes the cascade
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("cascade not stalled behind waiting result");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_data))
        else $error("result changed while held");

    // clamped pass count within the built stages
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(MAX_PASSES) >= pass_n)
        else $error("pass count beyond cascade");

    // clamped width within the line store
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_w >= WW'(3)) && (eff_w <= WW'(MAX_WIDTH)))
        else $error("width out of range");
`endif

endmodule

@@ verif/csf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_checker
// Watches the pixel, result and register channels of the sharpening cascade,
// predicts every result from the accepted pixels and compares in order.
// ----------------------------------------------------------------------------
module csf_checker import csf_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_PASSES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    // pixel token as it moves between passes
    typedef struct {
        bit          vld;
        bit          first;
        bit          last;
        logic [23:0] pix;
    } t_pass_tok;

    logic [23:0] row_mem [MAX_PASSES][2][MAX_WIDTH];
    logic [23:0] win     [MAX_PASSES][3][3];
    int unsigned pass_col  [MAX_PASSES];
    int unsigned pass_row  [MAX_PASSES];
    int unsigned pass_fill [MAX_PASSES];
    bit          pass_live [MAX_PASSES];
    int unsigned byp_col, byp_row;
    bit          byp_live;
    int unsigned passes_reg, width_reg, height_reg;
    t_out_item   result_q [$];
    int          fails;

    initial begin
        foreach (row_mem[s, r, c]) row_mem[s][r][c] = '0;
        fails = 0;
    end

    // saturate one channel of the kernel sum
    function automatic logic [7:0] clip_chan(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [23:0] sharpen_window(input int s);
        logic [23:0] res;
        int v;
        for (int sh = 0; sh < 24; sh += 8) begin
            v = 5 * int'(win[s][1][1][sh +: 8]) - int'(win[s][1][0][sh +: 8])
              - int'(win[s][1][2][sh +: 8]) - int'(win[s][0][1][sh +: 8])
              - int'(win[s][2][1][sh +: 8]);
            res[sh +: 8] = clip_chan(v);
        end
        return res;
    endfunction

    // one pass: line stores, window shift, border zeroing
    task automatic run_pass(input int s, input t_pass_tok tin, input int unsigned w,
                            input int unsigned h, output t_pass_tok tout);
        logic [23:0] x, a, b;
        int unsigned col, oc, orow;
        tout = '{vld: 0, first: 0, last: 0, pix: '0};
        if (tin.vld && tin.first) begin
            pass_live[s] = 1;
            pass_col[s]  = 0;
            pass_row[s]  = 0;
            pass_fill[s] = 0;
        end
        if (!pass_live[s]) return;
        x   = tin.vld ? tin.pix : 24'd0;
        col = pass_col[s];
        if (col >= w) col = 0;
        a = row_mem[s][0][col];
        b = row_mem[s][1][col];
        row_mem[s][0][col] = b;
        row_mem[s][1][col] = x;
        for (int r = 0; r < 3; r++) begin
            win[s][r][0] = win[s][r][1];
            win[s][r][1] = win[s][r][2];
        end
        win[s][0][2] = a;
        win[s][1][2] = b;
        win[s][2][2] = x;
        pass_col[s] = (col + 1 >= w) ? 0 : col + 1;
        if (pass_fill[s] <= w) begin
            pass_fill[s]++;
            return;
        end
        oc   = (col == 0) ? w - 1 : col - 1;
        orow = pass_row[s];
        if (orow >= h) orow = h - 1;
        tout.vld   = 1;
        tout.first = (orow == 0 && oc == 0);
        tout.last  = (orow == h - 1 && oc == w - 1);
        if (orow == 0 || orow == h - 1 || oc == 0 || oc == w - 1)
            tout.pix = '0;
        else
            tout.pix = sharpen_window(s);
        if (oc == w - 1) begin
            if (tout.last) pass_live[s] = 0;
            else pass_row[s] = orow + 1;
        end
    endtask

    // expected result of one accepted transfer, if any
    task automatic predict_pixel(input t_in_item it);
        int unsigned w, h, n;
        bit byp_end;
        t_pass_tok tk, nx;
        t_out_item res;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        h = (height_reg < 3) ? 3 : (height_reg > HEIGHT_MAX ? HEIGHT_MAX : height_reg);
        n = (passes_reg > MAX_PASSES) ? MAX_PASSES : passes_reg;
        byp_end = 0;
        tk.vld   = !it.flush;
        tk.first = tk.vld && it.frame_start;
        tk.last  = 0;
        tk.pix   = {it.chan_c, it.chan_b, it.chan_a};
        if (tk.vld) begin
            if (tk.first) begin
                byp_live = 1;
                byp_col  = 0;
                byp_row  = 0;
            end
            if (byp_live) begin
                if (byp_col >= w) byp_col = w - 1;
                if (byp_row >= h) byp_row = h - 1;
                byp_end = (byp_row == h - 1 && byp_col == w - 1);
                if (byp_end) begin
                    byp_live = 0;
                end else if (byp_col + 1 >= w) begin
                    byp_col = 0;
                    byp_row++;
                end else begin
                    byp_col++;
                end
            end
        end
        if (n == 0) begin
            tk.last = byp_end;
        end else begin
            for (int s = 0; s < n; s++) begin
                run_pass(s, tk, w, h, nx);
                tk = nx;
            end
        end
        if (!tk.vld) return;
        res.out_a     = tk.pix[7:0];
        res.out_b     = tk.pix[15:8];
        res.out_c     = tk.pix[23:16];
        res.frame_end = tk.last;
        result_q.push_back(res);
    endtask

    // watch all channels at each edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (win[s, r, c]) win[s][r][c] = '0;
            foreach (pass_live[s]) begin
                pass_col[s]  = 0;
                pass_row[s]  = 0;
                pass_fill[s] = 0;
                pass_live[s] = 0;
            end
            byp_col    = 0;
            byp_row    = 0;
            byp_live   = 0;
            passes_reg = 0;
            width_reg  = 640;
            height_reg = 480;
            result_q.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_PASS_COUNT:   passes_reg = i_pwdata[3:0];
                    REG_FRAME_WIDTH:  width_reg  = i_pwdata[11:0];
                    REG_FRAME_HEIGHT: height_reg = i_pwdata[11:0];
                    default: ;
                endcase
            end
            // pixel transfer
            if (i_in_valid && i_in_ready) predict_pixel(i_in_data);
            // result transfer
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %h", i_out_data);
                end else begin
                    want = result_q.pop_front();
                    if (want !== i_out_data) begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: expected a=%h b=%h c=%h end=%b, ",
                                      "got a=%h b=%h c=%h end=%b"},
                                     want.out_a, want.out_b, want.out_c, want.frame_end,
                                     i_out_data.out_a, i_out_data.out_b, i_out_data.out_c,
                                     i_out_data.frame_end);
                    end
                end
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= fails + result_q.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sharpening cascade: directed frames with extreme pixels,
// then random frames over many register settings with idling and a long
// result stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import csf_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int CALM_AT     = 440;
    localparam int PIX_TARGET  = 520;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          calm = 0;
    bit          hold_req = 0;
    int          pixels_sent = 0;
    int          cycles = 0;

    always #2 i_clk = ~i_clk;

    cascaded_sharpen_filter_3x3_top dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    csf_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("cascaded_sharpen_filter_3x3_top test failed");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        bit held;
        held = 0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                held = 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // register write: setup, access, then a return to idle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int p, input int w, input int h);
        reg_write(REG_PASS_COUNT, p);
        reg_write(REG_FRAME_WIDTH, w);
        reg_write(REG_FRAME_HEIGHT, h);
    endtask

    // one transfer with optional leading gap
    task automatic send(input t_in_item it);
        if (pixels_sent > CALM_AT) calm = 1;
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!it.flush) pixels_sent++;
    endtask

    function automatic t_in_item make_pixel(input bit start);
        t_in_item it;
        it.chan_a = 8'($urandom_range(0, 255));
        it.chan_b = 8'($urandom_range(0, 255));
        it.chan_c = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: it.chan_a = 8'hff;
            1: it.chan_b = 8'h00;
            default: ;
        endcase
        it.flush       = 1'b0;
        it.frame_start = start;
        return it;
    endfunction

    task automatic send_flushes(input int cnt);
        t_in_item it;
        for (int i = 0; i < cnt; i++) begin
            it = make_pixel($urandom_range(0, 1) == 1);
            it.flush = 1'b1;
            send(it);
        end
    endtask

    // full frame of random pixels, first one marked
    task automatic send_frame(input int w, input int h);
        for (int i = 0; i < w * h; i++) send(make_pixel(i == 0));
    endtask

    // wait for every expected result, then the pipeline depth
    task automatic drain();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic int eff_passes(input int p);
        return (p > 10) ? 10 : p;
    endfunction

    initial begin
        t_in_item it;
        int p, w, h, nframes, k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation high and low on a 3x3 frame
        set_regs(1, 3, 3);
        for (int i = 0; i < 9; i++) begin
            it = '{chan_a: 8'h00, chan_b: 8'h00, chan_c: 8'h00, flush: 1'b0,
                   frame_start: (i == 0)};
            if (i == 4) it = '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0};
            send(it);
        end
        for (int i = 0; i < 9; i++) begin
            it = '{8'hff, 8'hff, 8'hff, 1'b0, (i == 0)};
            if (i == 4) it = '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
            send(it);
        end
        send_flushes(6);
        drain();

        // directed: bypass with stray pixel, extra pixel and flushes
        set_regs(0, 0, 0);
        send(make_pixel(0));
        send_frame(3, 3);
        send(make_pixel(0));
        send_flushes(2);
        drain();

        // directed: early frame start restarts the pass
        set_regs(1, 3, 3);
        for (int i = 0; i < 4; i++) send(make_pixel(i == 0));
        send_frame(3, 3);
        send_flushes(4);
        drain();

        // saturating register values: wide bypass start, tall partial frame
        set_regs(0, 4095, 4095);
        for (int i = 0; i < 20; i++) send(make_pixel(i == 0));
        drain();
        set_regs(2, 3, 4095);
        for (int i = 0; i < 90; i++) send(make_pixel(i == 0));
        send_flushes(8);
        drain();
        set_regs(15, 3, 4);
        send_frame(3, 4);
        send_flushes(40);
        drain();

        // random phases
        for (int ph = 0; pixels_sent < PIX_TARGET; ph++) begin
            p = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 6);
            if (ph == 3) begin
                // pass-through frame so results back up early during the hold
                p = 0;
                w = 9;
                h = 6;
                hold_req = 1;
            end
            set_regs(p, w, h);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                if ($urandom_range(0, 4) == 0) send(make_pixel(0));
                if ($urandom_range(0, 5) == 0) begin
                    k = $urandom_range(1, w * 2);
                    for (int i = 0; i < k; i++) send(make_pixel(i == 0));
                end
                send_frame(w, h);
                if ($urandom_range(0, 3) == 0) send_flushes($urandom_range(1, 3));
            end
            send_flushes(eff_passes(p) * (w + 1) + $urandom_range(0, 3));
            drain();
        end

        if (fail_count == 0) begin
            $display("cascaded_sharpen_filter_3x3_top test passed");
        end else begin
            $display("cascaded_sharpen_filter_3x3_top test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/csf_pkg.sv
design/csf_ram.sv
design/csf_stage.sv
design/cascaded_sharpen_filter_3x3_top.sv
verif/csf_checker.sv
verif/tb.sv
